### rtl/uvs_pkg.sv
// uvs_pkg: shared constants, types and helper functions for the uv sphere generator
// no dependencies; imported by uvs_cordic and uv_sphere_mesh_generator
package uvs_pkg;

    localparam int IDX_W        = 17;
    localparam int COORD_W      = 17;
    localparam int PH_W         = 32;
    localparam int ATAN_ENTRIES = 24;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    localparam logic [1:0] REG_STACKS = 2'd0;
    localparam logic [1:0] REG_SLICES = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [8:0]  RST_STACKS = 9'd16;
    localparam logic [8:0]  RST_SLICES = 9'd16;
    localparam logic [15:0] RST_RADIUS = 16'd256;

    localparam logic signed [31:0] CORDIC_X0 = 32'sh26DD_3B6A;
    localparam logic signed [31:0] Q30_ONE   = 32'sh4000_0000;

    typedef enum logic [1:0] {
        QD_FIRST,
        QD_SECOND,
        QD_THIRD,
        QD_FOURTH
    } t_quad;

    typedef enum logic [1:0] {
        RG_BODY,
        RG_NORTH,
        RG_SOUTH
    } t_region;

    // word entering the index divider
    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [IDX_W-1:0] k;
    } t_sb0;

    // word after the index divider
    typedef struct packed {
        logic             valid;
        logic             kind;
        logic             oor;
        logic             pole_s;
        logic             pole_n;
        t_region          region;
        logic             odd;
        logic [IDX_W-1:0] in;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] ci;
    } t_tri1;

    // word travelling alongside the trig path
    typedef struct packed {
        logic             valid;
        logic             kind;
        logic             oor;
        logic             pole_s;
        logic             pole_n;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
    } t_sb;

    // arctangent of 2^-i in phase units (2^32 per turn)
    function automatic logic [31:0] atan_phase(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h2000_0000;
            1:       v = 32'h12E4_051E;
            2:       v = 32'h09FB_385B;
            3:       v = 32'h0511_11D4;
            4:       v = 32'h028B_0D43;
            5:       v = 32'h0145_D7E1;
            6:       v = 32'h00A2_F61E;
            7:       v = 32'h0051_7C55;
            8:       v = 32'h0028_BE53;
            9:       v = 32'h0014_5F2F;
            10:      v = 32'h000A_2F98;
            11:      v = 32'h0005_17CC;
            12:      v = 32'h0002_8BE6;
            13:      v = 32'h0001_45F3;
            14:      v = 32'h0000_A2FA;
            15:      v = 32'h0000_517D;
            16:      v = 32'h0000_28BE;
            17:      v = 32'h0000_145F;
            18:      v = 32'h0000_0A30;
            19:      v = 32'h0000_0518;
            20:      v = 32'h0000_028C;
            21:      v = 32'h0000_0146;
            22:      v = 32'h0000_00A3;
            23:      v = 32'h0000_0051;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v > Q30_ONE) begin
            r = Q30_ONE;
        end else if (v < -Q30_ONE) begin
            r = -Q30_ONE;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [30:0] mag_q30(input logic signed [31:0] v);
        logic [31:0] neg;
        neg = 32'(-v);
        return v[31] ? neg[30:0] : v[30:0];
    endfunction

    function automatic logic [COORD_W-1:0] to_field(input logic [COORD_W-1:0] m,
                                                    input logic neg);
        return neg ? COORD_W'(-m) : m;
    endfunction

endpackage

### rtl/uvs_div.sv
// uvs_div: pipelined restoring divider, one quotient bit per register stage
// depends on nothing but the clock enable from the caller
module uvs_div #(
    parameter int NSTG = 17,
    parameter int DVW  = 9
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [DVW-1:0]  i_rem,
    input  logic [NSTG-1:0] i_low,
    input  logic [DVW-1:0]  i_dvs,
    output logic [NSTG-1:0] o_quo,
    output logic [DVW-1:0]  o_rem
);

    logic [DVW-1:0]  r_rem [NSTG];
    logic [DVW-1:0]  r_dvs [NSTG];
    logic [NSTG-1:0] r_low [NSTG];
    logic [NSTG-1:0] r_quo [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic [DVW-1:0]  w_rem;
        logic [DVW-1:0]  w_dvs;
        logic [NSTG-1:0] w_low;
        logic [NSTG-1:0] w_quo;
        logic [DVW:0]    w_sh;
        logic            w_ge;
        logic [DVW-1:0]  n_rem;
        logic [NSTG-1:0] n_low;
        logic [NSTG-1:0] n_quo;

        if (g == 0) begin : g_first
            assign w_rem = i_rem;
            assign w_dvs = i_dvs;
            assign w_low = i_low;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = r_rem[g-1];
            assign w_dvs = r_dvs[g-1];
            assign w_low = r_low[g-1];
            assign w_quo = r_quo[g-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign w_sh  = {w_rem, w_low[NSTG-1]};
        assign w_ge  = (w_sh >= {1'b0, w_dvs});
        assign n_rem = w_ge ? DVW'(w_sh - {1'b0, w_dvs}) : w_sh[DVW-1:0];
        assign n_low = {w_low[NSTG-2:0], 1'b0};
        assign n_quo = {w_quo[NSTG-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_dvs[g] <= w_dvs;
                r_low[g] <= n_low;
                r_quo[g] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[NSTG-1];
    assign o_rem = r_rem[NSTG-1];

endmodule

### rtl/uvs_cordic.sv
// uvs_cordic: pipelined rotation-mode cordic giving sin and cos of a 32-bit phase in q2.30
// depends on uvs_pkg for the arctangent table, clamp and quadrant type
module uvs_cordic #(
    parameter int NSTG = 18
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [uvs_pkg::PH_W-1:0]  i_phase,
    output logic signed [31:0]        o_sin,
    output logic signed [31:0]        o_cos
);

    import uvs_pkg::*;

    logic signed [31:0] r_x [NSTG];
    logic signed [31:0] r_y [NSTG];
    logic signed [31:0] r_z [NSTG];
    logic [1:0]         r_q [NSTG];
    logic signed [31:0] r_sin;
    logic signed [31:0] r_cos;
    logic signed [31:0] n_sin;
    logic signed [31:0] n_cos;
    logic signed [31:0] w_cx;
    logic signed [31:0] w_cy;

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic signed [31:0] w_x;
        logic signed [31:0] w_y;
        logic signed [31:0] w_z;
        logic [1:0]         w_q;
        logic signed [31:0] w_at;
        logic signed [31:0] n_x;
        logic signed [31:0] n_y;
        logic signed [31:0] n_z;

        if (g == 0) begin : g_first
            assign w_x = CORDIC_X0;
            assign w_y = '0;
            assign w_z = $signed({2'b00, i_phase[PH_W-3:0]});
            assign w_q = i_phase[PH_W-1:PH_W-2];
        end else begin : g_next
            assign w_x = r_x[g-1];
            assign w_y = r_y[g-1];
            assign w_z = r_z[g-1];
            assign w_q = r_q[g-1];
        end

        assign w_at = $signed(atan_phase(g));
        assign n_x  = w_z[31] ? (w_x + (w_y >>> g)) : (w_x - (w_y >>> g));
        assign n_y  = w_z[31] ? (w_y - (w_x >>> g)) : (w_y + (w_x >>> g));
        assign n_z  = w_z[31] ? (w_z + w_at) : (w_z - w_at);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g] <= n_x;
                r_y[g] <= n_y;
                r_z[g] <= n_z;
                r_q[g] <= w_q;
            end
        end
    end

    // clamp to the unit range, then rotate into the quadrant
    always_comb begin
        w_cx = clamp_unit(r_x[NSTG-1]);
        w_cy = clamp_unit(r_y[NSTG-1]);
        case (t_quad'(r_q[NSTG-1]))
            QD_FIRST: begin
                n_cos = w_cx;
                n_sin = w_cy;
            end
            QD_SECOND: begin
                n_cos = -w_cy;
                n_sin = w_cx;
            end
            QD_THIRD: begin
                n_cos = -w_cx;
                n_sin = -w_cy;
            end
            default: begin
                n_cos = w_cy;
                n_sin = -w_cx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

### rtl/uv_sphere_mesh_generator.sv
// uv_sphere_mesh_generator: top level of the uv sphere vertex and triangle generator
// depends on uvs_pkg, uvs_div and uvs_cordic
//
// One request word in gives one result word out, in order. A vertex request returns the
// position of vertex k as signed q8.8 x, y, z; a triangle request returns the three corner
// indices. The datapath is a single stall-free pipeline: a new word may be taken every
// cycle, and the whole pipeline advances whenever the output register is empty or being
// taken, so back-pressure on the output only freezes it. The result path runs through the
// 17-stage index divider, the 32-stage phase dividers (ring and column angles), the cordic
// stages plus one quadrant stage, the first multiply stage and the output register, which
// takes the second multiply. The user must write stacks, slices and radius over the apb port
// only while no words are in flight; the block itself does not enforce this. Out-of-range
// stack and slice counts are clamped to [2, MAX_STACKS] and [3, MAX_SLICES].
module uv_sphere_mesh_generator #(
    parameter int MAX_STACKS    = 256,
    parameter int MAX_SLICES    = 256,
    parameter int CORDIC_STAGES = 18
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // request channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_kind,
    input  logic [uvs_pkg::IDX_W-1:0]          i_item_index,
    // result channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_kind_echo,
    output logic signed [uvs_pkg::COORD_W-1:0] o_coord_x,
    output logic signed [uvs_pkg::COORD_W-1:0] o_coord_y,
    output logic signed [uvs_pkg::COORD_W-1:0] o_coord_z,
    output logic [uvs_pkg::IDX_W-1:0]          o_corner_a,
    output logic [uvs_pkg::IDX_W-1:0]          o_corner_b,
    output logic [uvs_pkg::IDX_W-1:0]          o_corner_c,
    output logic                               o_out_of_range
);

    import uvs_pkg::*;

    localparam int TW  = $clog2(MAX_STACKS + 1);
    localparam int SW  = $clog2(MAX_SLICES + 1);
    localparam int NW  = $clog2(MAX_SLICES + 2);
    localparam int VW  = TW + NW + 1;
    localparam int CW  = ((VW > IDX_W) ? VW : IDX_W) + 1;
    localparam int PW  = IDX_W + NW;
    localparam int NC  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int D1  = IDX_W;
    localparam int DL  = PH_W + NC;
    localparam int MW  = 62;
    localparam int RW  = 47;
    localparam logic [MW-1:0] RND_M = MW'(64'h2000_0000);
    localparam logic [RW-1:0] RND_R = RW'(64'h2000_0000);

    // ---------------------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------------------
    logic [8:0]  r_stacks;
    logic [8:0]  r_slices;
    logic [15:0] r_radius;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stacks <= RST_STACKS;
            r_slices <= RST_SLICES;
            r_radius <= RST_RADIUS;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_STACKS: r_stacks <= pwdata[8:0];
                REG_SLICES: r_slices <= pwdata[8:0];
                REG_RADIUS: r_radius <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_STACKS: prdata = 32'(r_stacks);
            REG_SLICES: prdata = 32'(r_slices);
            REG_RADIUS: prdata = 32'(r_radius);
            default:    prdata = '0;
        endcase
    end

    // effective counts and the mesh sizes they imply (the user must keep them static while words are in flight)
    logic [TW-1:0] t_eff;
    logic [SW-1:0] s_eff;
    logic [NW-1:0] n_eff;
    logic [VW-1:0] nverts;
    logic [VW-1:0] nbody;
    logic [VW-1:0] ntri;
    logic [IDX_W-1:0] south_base;

    always_comb begin
        if (r_stacks < 9'd2) begin
            t_eff = TW'(2);
        end else if (int'(r_stacks) > MAX_STACKS) begin
            t_eff = TW'(MAX_STACKS);
        end else begin
            t_eff = TW'(r_stacks);
        end
        if (r_slices < 9'd3) begin
            s_eff = SW'(3);
        end else if (int'(r_slices) > MAX_SLICES) begin
            s_eff = SW'(MAX_SLICES);
        end else begin
            s_eff = SW'(r_slices);
        end
        n_eff      = NW'(s_eff) + NW'(1);
        nverts     = VW'(VW'(t_eff - TW'(1)) * VW'(n_eff)) + VW'(2);
        nbody      = VW'(VW'({s_eff, 1'b0}) * VW'(t_eff - TW'(2)));
        ntri       = nbody + VW'({s_eff, 1'b0});
        south_base = IDX_W'(VW'(t_eff - TW'(2)) * VW'(n_eff));
    end

    // ---------------------------------------------------------------------------------
    // pipeline advance: everything moves unless a finished word is held at the output
    // ---------------------------------------------------------------------------------
    logic r_ovalid;
    logic w_en;

    assign w_en    = ~r_ovalid | i_ready;
    assign o_ready = w_en;

    // ---------------------------------------------------------------------------------
    // index divider: vertex k / (slices+1) gives ring and column,
    // triangle (k/2) / slices gives quad row and column
    // ---------------------------------------------------------------------------------
    logic [IDX_W-1:0] w_d1_low;
    logic [NW-1:0]    w_d1_dvs;
    logic [IDX_W-1:0] d1_quo;
    logic [NW-1:0]    d1_rem;
    t_sb0             r_sb0 [D1];

    assign w_d1_low = (i_kind == KIND_TRIANGLE) ? {1'b0, i_item_index[IDX_W-1:1]}
                                                : i_item_index;
    assign w_d1_dvs = (i_kind == KIND_TRIANGLE) ? NW'(s_eff) : n_eff;

    uvs_div #(
        .NSTG (D1),
        .DVW  (NW)
    ) u_div_idx (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem ('0),
        .i_low (w_d1_low),
        .i_dvs (w_d1_dvs),
        .o_quo (d1_quo),
        .o_rem (d1_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < D1; i++) begin
                r_sb0[i] <= '0;
            end
        end else if (w_en) begin
            r_sb0[0] <= '{valid: i_valid, kind: i_kind, k: i_item_index};
            for (int i = 1; i < D1; i++) begin
                r_sb0[i] <= r_sb0[i-1];
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // triangle corners, first stage: range checks and pole flags for both kinds, region and row base
    // ---------------------------------------------------------------------------------
    t_sb0          w_sb0;
    logic [CW-1:0] w_kx;
    t_tri1         n_t1;
    t_tri1         r_t1;

    assign w_sb0 = r_sb0[D1-1];

    always_comb begin
        w_kx         = CW'(w_sb0.k);
        n_t1.valid   = w_sb0.valid;
        n_t1.kind    = w_sb0.kind;
        n_t1.odd     = w_sb0.k[0];
        n_t1.in      = IDX_W'(PW'(d1_quo) * PW'(n_eff));
        n_t1.j       = IDX_W'(d1_rem);
        if (w_sb0.kind == KIND_VERTEX) begin
            n_t1.oor    = (w_kx >= CW'(nverts));
            n_t1.pole_s = (w_kx == CW'(nverts) - CW'(2));
            n_t1.pole_n = (w_kx == CW'(nverts) - CW'(1));
        end else begin
            n_t1.oor    = (w_kx >= CW'(ntri));
            n_t1.pole_s = 1'b0;
            n_t1.pole_n = 1'b0;
        end
        if (w_kx < CW'(nbody)) begin
            n_t1.region = RG_BODY;
            n_t1.ci     = '0;
        end else if (w_kx - CW'(nbody) < CW'(s_eff)) begin
            n_t1.region = RG_NORTH;
            n_t1.ci     = IDX_W'(w_kx - CW'(nbody));
        end else begin
            n_t1.region = RG_SOUTH;
            n_t1.ci     = IDX_W'(w_kx - CW'(nbody) - CW'(s_eff));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
        end else if (w_en) begin
            r_t1 <= n_t1;
        end
    end

    // ---------------------------------------------------------------------------------
    // triangle corners, second stage, then a delay line matching the trig path
    // ---------------------------------------------------------------------------------
    logic [IDX_W-1:0] w_nn;
    t_sb              n_sb;
    t_sb              r_dl [DL+1];

    always_comb begin
        w_nn        = IDX_W'(n_eff);
        n_sb.valid  = r_t1.valid;
        n_sb.kind   = r_t1.kind;
        n_sb.oor    = r_t1.oor;
        n_sb.pole_s = r_t1.pole_s;
        n_sb.pole_n = r_t1.pole_n;
        case (r_t1.region)
            RG_BODY: begin
                if (r_t1.odd) begin
                    n_sb.a = r_t1.in + w_nn + r_t1.j;
                    n_sb.b = r_t1.in + r_t1.j + IDX_W'(1);
                    n_sb.c = r_t1.in + w_nn + r_t1.j + IDX_W'(1);
                end else begin
                    n_sb.a = r_t1.in + r_t1.j;
                    n_sb.b = r_t1.in + r_t1.j + IDX_W'(1);
                    n_sb.c = r_t1.in + w_nn + r_t1.j;
                end
            end
            RG_NORTH: begin
                // fan around the north pole
                n_sb.a = IDX_W'(nverts - VW'(1));
                n_sb.b = r_t1.ci + IDX_W'(1);
                n_sb.c = r_t1.ci;
            end
            RG_SOUTH: begin
                // fan around the south pole on the last ring
                n_sb.a = IDX_W'(nverts - VW'(2));
                n_sb.b = south_base + r_t1.ci;
                n_sb.c = south_base + r_t1.ci + IDX_W'(1);
            end
            default: begin
                n_sb.a = '0;
                n_sb.b = '0;
                n_sb.c = '0;
            end
        endcase
        if (r_t1.kind == KIND_VERTEX || r_t1.oor) begin
            n_sb.a = '0;
            n_sb.b = '0;
            n_sb.c = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DL; i++) begin
                r_dl[i] <= '0;
            end
        end else if (w_en) begin
            r_dl[0] <= n_sb;
            for (int i = 1; i <= DL; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // angle phases: phi = round(ring * 2^31 / stacks), theta = round(col * 2^32 / slices)
    // phi is divided at double scale so both dividers have 32 stages
    // ---------------------------------------------------------------------------------
    logic [TW-1:0]   w_ring;
    logic [SW-1:0]   w_col;
    logic [SW-1:0]   w_th_rem;
    logic [PH_W-1:0] w_phi_low;
    logic [PH_W-1:0] w_th_low;
    logic [PH_W-1:0] phi_quo;
    logic [PH_W-1:0] th_quo;
    logic [TW-1:0]   phi_rem;
    logic [SW-1:0]   th_rem;
    logic [PH_W-1:0] w_ph_phi;

    assign w_ring    = TW'(d1_quo) + TW'(1);
    assign w_col     = SW'(d1_rem);
    // the seam column wraps to a full turn, i.e. phase zero
    assign w_th_rem  = (w_col == s_eff) ? '0 : w_col;
    assign w_phi_low = {(PH_W-1)'(t_eff >> 1), 1'b0};
    assign w_th_low  = PH_W'(s_eff >> 1);

    uvs_div #(
        .NSTG (PH_W),
        .DVW  (TW)
    ) u_div_phi (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (w_ring),
        .i_low (w_phi_low),
        .i_dvs (t_eff),
        .o_quo (phi_quo),
        .o_rem (phi_rem)
    );

    uvs_div #(
        .NSTG (PH_W),
        .DVW  (SW)
    ) u_div_theta (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (w_th_rem),
        .i_low (w_th_low),
        .i_dvs (s_eff),
        .o_quo (th_quo),
        .o_rem (th_rem)
    );

    assign w_ph_phi = {1'b0, phi_quo[PH_W-1:1]};

    // ---------------------------------------------------------------------------------
    // sin and cos of both angles
    // ---------------------------------------------------------------------------------
    logic signed [31:0] sin_phi;
    logic signed [31:0] cos_phi;
    logic signed [31:0] sin_th;
    logic signed [31:0] cos_th;

    uvs_cordic #(
        .NSTG (NC)
    ) u_cordic_phi (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_ph_phi),
        .o_sin   (sin_phi),
        .o_cos   (cos_phi)
    );

    uvs_cordic #(
        .NSTG (NC)
    ) u_cordic_theta (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (th_quo),
        .o_sin   (sin_th),
        .o_cos   (cos_th)
    );

    // ---------------------------------------------------------------------------------
    // first multiply stage: sin(phi) times cos/sin(theta), and cos(phi) times radius
    // magnitudes only, sign applied at the end so rounding is symmetric
    // ---------------------------------------------------------------------------------
    logic [30:0]         w_msp;
    logic [30:0]         w_mcp;
    logic [30:0]         w_mst;
    logic [30:0]         w_mct;
    logic [MW-1:0]       w_px;
    logic [MW-1:0]       w_pz;
    logic [RW-1:0]       w_py;
    logic [30:0]         r_m1x;
    logic [30:0]         r_m1z;
    logic [COORD_W-1:0]  r_my;
    logic                r_neg_x;
    logic                r_neg_y;
    logic                r_neg_z;

    always_comb begin
        w_msp = mag_q30(sin_phi);
        w_mcp = mag_q30(cos_phi);
        w_mst = mag_q30(sin_th);
        w_mct = mag_q30(cos_th);
        w_px  = MW'(w_msp) * MW'(w_mct) + RND_M;
        w_pz  = MW'(w_msp) * MW'(w_mst) + RND_M;
        w_py  = RW'(w_mcp) * RW'(r_radius) + RND_R;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1x   <= w_px[60:30];
            r_m1z   <= w_pz[60:30];
            r_my    <= w_py[46:30];
            r_neg_x <= sin_phi[31] ^ cos_th[31];
            r_neg_y <= cos_phi[31];
            r_neg_z <= sin_phi[31] ^ sin_th[31];
        end
    end

    // ---------------------------------------------------------------------------------
    // second multiply stage into the output register
    // ---------------------------------------------------------------------------------
    t_sb                w_sb;
    logic [RW-1:0]      w_qx;
    logic [RW-1:0]      w_qz;
    logic [COORD_W-1:0] n_x;
    logic [COORD_W-1:0] n_y;
    logic [COORD_W-1:0] n_z;
    logic [IDX_W-1:0]   n_a;
    logic [IDX_W-1:0]   n_b;
    logic [IDX_W-1:0]   n_c;
    logic               r_kind;
    logic               r_oor;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [COORD_W-1:0] r_z;
    logic [IDX_W-1:0]   r_a;
    logic [IDX_W-1:0]   r_b;
    logic [IDX_W-1:0]   r_c;

    assign w_sb = r_dl[DL];

    always_comb begin
        w_qx = RW'(r_m1x) * RW'(r_radius) + RND_R;
        w_qz = RW'(r_m1z) * RW'(r_radius) + RND_R;
        n_x  = '0;
        n_y  = '0;
        n_z  = '0;
        n_a  = w_sb.a;
        n_b  = w_sb.b;
        n_c  = w_sb.c;
        if (w_sb.oor) begin
            n_a = '0;
            n_b = '0;
            n_c = '0;
        end else if (w_sb.kind == KIND_VERTEX) begin
            if (w_sb.pole_s) begin
                n_y = to_field(COORD_W'(r_radius), 1'b1);
            end else if (w_sb.pole_n) begin
                n_y = COORD_W'(r_radius);
            end else begin
                n_x = to_field(w_qx[46:30], r_neg_x);
                n_y = to_field(r_my, r_neg_y);
                n_z = to_field(w_qz[46:30], r_neg_z);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= w_sb.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind <= w_sb.kind;
            r_oor  <= w_sb.oor;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_a    <= n_a;
            r_b    <= n_b;
            r_c    <= n_c;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_kind_echo    = r_kind;
    assign o_out_of_range = r_oor;
    assign o_coord_x      = $signed(r_x);
    assign o_coord_y      = $signed(r_y);
    assign o_coord_z      = $signed(r_z);
    assign o_corner_a     = r_a;
    assign o_corner_b     = r_b;
    assign o_corner_c     = r_c;

endmodule
